@@ rtl/r2fft_pkg.sv @@
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types, codes and twiddle table functions of the radix-2 FFT core.
// ----------------------------------------------------------------------------
package r2fft_pkg;

    // item kinds carried in each input word
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    // configuration register indexes
    typedef enum logic {
        CFG_INVERSE = 1'b0,
        CFG_LOG     = 1'b1
    } t_cfg_reg;

    localparam int          DATA_WIDTH  = 32;
    localparam int          INDEX_WIDTH = 10;
    localparam int          CFG_WIDTH   = 4;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // cosine series, truncated terms, Q30
    function automatic logic signed [63:0] cos_series(input logic [63:0] x2);
        logic [63:0]        t;
        logic signed [63:0] s;
        t = ONE_Q30;         s = signed'(t);
        t = ((t * x2) >> 30) / 64'd2;   s = s - signed'(t);
        t = ((t * x2) >> 30) / 64'd12;  s = s + signed'(t);
        t = ((t * x2) >> 30) / 64'd30;  s = s - signed'(t);
        t = ((t * x2) >> 30) / 64'd56;  s = s + signed'(t);
        t = ((t * x2) >> 30) / 64'd90;  s = s - signed'(t);
        t = ((t * x2) >> 30) / 64'd132; s = s + signed'(t);
        t = ((t * x2) >> 30) / 64'd182; s = s - signed'(t);
        t = ((t * x2) >> 30) / 64'd240; s = s + signed'(t);
        t = ((t * x2) >> 30) / 64'd306; s = s - signed'(t);
        t = ((t * x2) >> 30) / 64'd380; s = s + signed'(t);
        t = ((t * x2) >> 30) / 64'd462; s = s - signed'(t);
        t = ((t * x2) >> 30) / 64'd552; s = s + signed'(t);
        return s;
    endfunction

    // sine series, truncated terms, Q30
    function automatic logic signed [63:0] sin_series(input logic [63:0] x,
                                                      input logic [63:0] x2);
        logic [63:0]        t;
        logic signed [63:0] s;
        t = x;               s = signed'(t);
        t = ((t * x2) >> 30) / 64'd6;   s = s - signed'(t);
        t = ((t * x2) >> 30) / 64'd20;  s = s + signed'(t);
        t = ((t * x2) >> 30) / 64'd42;  s = s - signed'(t);
        t = ((t * x2) >> 30) / 64'd72;  s = s + signed'(t);
        t = ((t * x2) >> 30) / 64'd110; s = s - signed'(t);
        t = ((t * x2) >> 30) / 64'd156; s = s + signed'(t);
        t = ((t * x2) >> 30) / 64'd210; s = s - signed'(t);
        t = ((t * x2) >> 30) / 64'd272; s = s + signed'(t);
        t = ((t * x2) >> 30) / 64'd342; s = s - signed'(t);
        t = ((t * x2) >> 30) / 64'd420; s = s + signed'(t);
        t = ((t * x2) >> 30) / 64'd506; s = s - signed'(t);
        t = ((t * x2) >> 30) / 64'd600; s = s + signed'(t);
        return s;
    endfunction

    // Q30 to frac bits, round half away from zero, clamp to 1.0
    function automatic logic signed [31:0] to_frac(input logic signed [63:0] v,
                                                   input int frac);
        logic        neg;
        logic [63:0] m;
        logic [63:0] r;
        neg = v[63];
        m   = neg ? 64'(-v) : 64'(v);
        r   = (m + (64'd1 << (29 - frac))) >> (30 - frac);
        if (r > (64'd1 << frac)) r = 64'd1 << frac;
        return neg ? -signed'(32'(r)) : signed'(32'(r));
    endfunction

    // twiddle entry k of cos/sin(pi*k/2^(max_log-1))
    function automatic logic signed [31:0] tw_value(input int k, input int max_log,
                                                    input int frac, input logic want_sin);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic               mirror;
        logic signed [63:0] c;
        x      = (PI_Q30 * 64'(k) + ((64'd1 << (max_log - 1)) >> 1)) >> (max_log - 1);
        mirror = x > HALF_PI_Q30;
        if (mirror) x = PI_Q30 - x;
        x2 = (x * x) >> 30;
        c  = cos_series(x2);
        if (want_sin) return to_frac(sin_series(x, x2), frac);
        return to_frac(mirror ? -c : c, frac);
    endfunction

endpackage

@@ rtl/r2fft_ifs.sv @@
// ----------------------------------------------------------------------------
// r2fft_ifs
// Valid/ready channels of the FFT core: item input, result output, config.
// ----------------------------------------------------------------------------
interface r2fft_in_if #(parameter int SAMPLE_WIDTH = 16);
    logic                             valid;
    logic                             ready;
    logic [1:0]                       kind;
    logic [r2fft_pkg::INDEX_WIDTH-1:0] index;
    logic signed [SAMPLE_WIDTH-1:0]   in_real;
    logic signed [SAMPLE_WIDTH-1:0]   in_imag;
    modport source (output valid, kind, index, in_real, in_imag, input ready);
    modport sink   (input valid, kind, index, in_real, in_imag, output ready);
endinterface

interface r2fft_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [r2fft_pkg::DATA_WIDTH-1:0] out_real;
    logic signed [r2fft_pkg::DATA_WIDTH-1:0] out_imag;
    logic [1:0]                            done_kind;
    modport source (output valid, out_real, out_imag, done_kind, input ready);
    modport sink   (input valid, out_real, out_imag, done_kind, output ready);
endinterface

interface r2fft_cfg_if;
    logic                            valid;
    logic                            ready;
    logic                            index;
    logic [r2fft_pkg::CFG_WIDTH-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/radix2_complex_fft_core.sv @@
// ----------------------------------------------------------------------------
// radix2_complex_fft_core
// In-place radix-2 decimation-in-time complex FFT over a sample memory.
// ----------------------------------------------------------------------------
// A write word stores one sample and a read word returns one entry through
// the registered memory read; each then hands a result word to the output.
// A run word transforms the first N = 2^log_points entries, log_points
// clamped to 1..MAX_LOG_POINTS, with one shared 32 x (F+2) multiplier and a
// single-port-write memory: a bit-reverse pass swaps each reversed pair, then
// each butterfly reads both entries, forms twiddle products, writes both
// results; inverse mode ends with a divide-by-N pass. The core is not ready
// while it runs. Memory contents are undefined after reset until written.
module radix2_complex_fft_core #(
    parameter int MAX_LOG_POINTS    = 10,
    parameter int SAMPLE_WIDTH      = 16,
    parameter int TWIDDLE_FRAC_BITS = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    r2fft_in_if.sink      i_in,
    r2fft_out_if.source   o_out,
    r2fft_cfg_if.sink     i_cfg
);

    localparam int AW    = MAX_LOG_POINTS;
    localparam int DEPTH = 1 << AW;
    localparam int HALF  = 1 << (AW - 1);
    localparam int KW    = (AW > 1) ? AW - 1 : 1;
    localparam int LW    = $clog2(AW + 1);
    localparam int TW    = TWIDDLE_FRAC_BITS + 2;
    localparam int DW    = r2fft_pkg::DATA_WIDTH;
    localparam int PW    = DW + TW;
    localparam int SW    = SAMPLE_WIDTH;

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_RDW  = 14'b00000000000010,
        ST_SWC  = 14'b00000000000100,
        ST_SW1  = 14'b00000000001000,
        ST_SW2  = 14'b00000000010000,
        ST_SW3  = 14'b00000000100000,
        ST_BF0  = 14'b00000001000000,
        ST_BF1  = 14'b00000010000000,
        ST_BF2  = 14'b00000100000000,
        ST_MUL  = 14'b00001000000000,
        ST_WRP  = 14'b00010000000000,
        ST_WRQ  = 14'b00100000000000,
        ST_SC0  = 14'b01000000000000,
        ST_SC1  = 14'b10000000000000
    } t_state;

    t_state                   r_state;
    logic                     r_inverse;
    logic [r2fft_pkg::CFG_WIDTH-1:0] r_log_points;
    logic [LW-1:0]            r_len;
    logic [LW-1:0]            r_lvl;
    logic [AW-1:0]            r_i;
    logic [2:0]               r_s;
    logic [2*DW-1:0]          r_a;
    logic [2*DW-1:0]          r_b;
    logic signed [TW-1:0]     r_wc;
    logic signed [TW-1:0]     r_ws;
    logic signed [PW-1:0]     r_prod;
    logic signed [PW:0]       r_acc;
    logic [DW-1:0]            r_tr;
    logic [DW-1:0]            r_ti;
    logic                     r_ov;
    logic [DW-1:0]            r_out_re;
    logic [DW-1:0]            r_out_im;
    logic [1:0]               r_out_kind;
    logic [2*DW-1:0]          r_mem [DEPTH];
    logic [2*DW-1:0]          r_rd;

    logic signed [TW-1:0]     rom_cos [HALF];
    logic signed [TW-1:0]     rom_sin [HALF];

    logic                     in_acc;
    logic [AW-1:0]            in_idx;
    logic [AW-1:0]            n_mask;
    logic [AW-1:0]            half_mask;
    logic [AW-1:0]            rev_full;
    logic [AW-1:0]            rev;
    logic [AW-1:0]            bf_j;
    logic [AW-1:0]            bf_p;
    logic [AW-1:0]            bf_q;
    logic [KW-1:0]            tw_k;
    logic [LW-1:0]            len_eff;
    logic                     mem_we;
    logic [AW-1:0]            mem_wa;
    logic [2*DW-1:0]          mem_wd;
    logic [AW-1:0]            mem_ra;
    logic signed [DW-1:0]     mul_a;
    logic signed [TW-1:0]     mul_b;
    logic signed [TW-1:0]     w_im;
    logic signed [DW+1:0]     sc_re;
    logic signed [DW+1:0]     sc_im;

    // twiddle table, built at elaboration
    for (genvar g = 0; g < HALF; g++) begin : g_rom
        assign rom_cos[g] = TW'(r2fft_pkg::tw_value(g, AW, TWIDDLE_FRAC_BITS, 1'b0));
        assign rom_sin[g] = TW'(r2fft_pkg::tw_value(g, AW, TWIDDLE_FRAC_BITS, 1'b1));
    end

    // handshakes
    assign i_cfg.ready     = 1'b1;
    assign i_in.ready      = (r_state == ST_IDLE) && (!r_ov || o_out.ready);
    assign in_acc          = i_in.valid && i_in.ready;
    assign in_idx          = AW'(i_in.index);
    assign o_out.valid     = r_ov;
    assign o_out.out_real  = r_out_re;
    assign o_out.out_imag  = r_out_im;
    assign o_out.done_kind = r_out_kind;

    // length clamp and index math
    always_comb begin
        if (r_log_points == '0) len_eff = LW'(1);
        else if (32'(r_log_points) > AW) len_eff = LW'(AW);
        else len_eff = LW'(r_log_points);
        n_mask    = ~({AW{1'b1}} << r_len);
        half_mask = ~({AW{1'b1}} << (r_lvl - LW'(1)));
        for (int b = 0; b < AW; b++) rev_full[b] = r_i[AW-1-b];
        rev  = rev_full >> (LW'(AW) - r_len);
        bf_j = r_i & half_mask;
        bf_p = ((r_i & ~half_mask) << 1) | bf_j;
        bf_q = bf_p | (half_mask + AW'(1));
        tw_k = KW'(bf_j << (LW'(AW) - r_lvl));
    end

    // shared multiplier operand select
    always_comb begin
        w_im = r_inverse ? -r_ws : r_ws;
        unique case (r_s)
            3'd0:    begin mul_a = signed'(r_b[DW-1:0]);    mul_b = r_wc; end
            3'd1:    begin mul_a = signed'(r_b[2*DW-1:DW]); mul_b = w_im; end
            3'd2:    begin mul_a = signed'(r_b[DW-1:0]);    mul_b = w_im; end
            default: begin mul_a = signed'(r_b[2*DW-1:DW]); mul_b = r_wc; end
        endcase
    end

    // rounding divide by N for inverse mode
    always_comb begin
        sc_re = (DW+2)'(signed'(r_rd[DW-1:0])) + ((DW+2)'(1) <<< (r_len - LW'(1)));
        sc_im = (DW+2)'(signed'(r_rd[2*DW-1:DW])) + ((DW+2)'(1) <<< (r_len - LW'(1)));
        sc_re = sc_re >>> r_len;
        sc_im = sc_im >>> r_len;
    end

    // memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_i;
        mem_wd = r_rd;
        mem_ra = r_i;
        unique case (r_state)
            ST_IDLE: begin
                mem_ra = in_idx;
                mem_wa = in_idx;
                mem_wd = {DW'(signed'(i_in.in_imag[SW-1:0])),
                          DW'(signed'(i_in.in_real[SW-1:0]))};
                mem_we = in_acc && (r2fft_pkg::t_kind'(i_in.kind) == r2fft_pkg::KIND_WRITE);
            end
            ST_SW1:  mem_ra = rev;
            ST_SW2:  mem_we = 1'b1;
            ST_SW3:  begin mem_we = 1'b1; mem_wa = rev; mem_wd = r_a; end
            ST_BF0:  mem_ra = bf_p;
            ST_BF1:  mem_ra = bf_q;
            ST_WRP:  begin
                mem_we = 1'b1;
                mem_wa = bf_p;
                mem_wd = {r_a[2*DW-1:DW] + r_ti, r_a[DW-1:0] + r_tr};
            end
            ST_WRQ:  begin
                mem_we = 1'b1;
                mem_wa = bf_q;
                mem_wd = {r_a[2*DW-1:DW] - r_ti, r_a[DW-1:0] - r_tr};
            end
            ST_SC1:  begin mem_we = 1'b1; mem_wd = {DW'(sc_im), DW'(sc_re)}; end
            default: ;
        endcase
    end

    // sample memory
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[mem_ra];
    end

    // twiddle read, multiplier and datapath registers
    always_ff @(posedge i_clk) begin
        r_wc   <= rom_cos[tw_k];
        r_ws   <= rom_sin[tw_k];
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            ST_SW1: r_a <= r_rd;
            ST_BF1: r_a <= r_rd;
            ST_BF2: r_b <= r_rd;
            ST_MUL: begin
                if (r_s == 3'd1 || r_s == 3'd3)
                    r_acc <= (PW+1)'(r_prod) + ((PW+1)'(1) <<< (TWIDDLE_FRAC_BITS - 1));
                if (r_s == 3'd2) r_tr <= DW'((r_acc - (PW+1)'(r_prod)) >>> TWIDDLE_FRAC_BITS);
                if (r_s == 3'd4) r_ti <= DW'((r_acc + (PW+1)'(r_prod)) >>> TWIDDLE_FRAC_BITS);
            end
            default: ;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inverse    <= 1'b0;
            r_log_points <= r2fft_pkg::CFG_WIDTH'(10);
        end else if (i_cfg.valid) begin
            unique case (r2fft_pkg::t_cfg_reg'(i_cfg.index))
                r2fft_pkg::CFG_INVERSE: r_inverse    <= i_cfg.data[0];
                r2fft_pkg::CFG_LOG:     r_log_points <= i_cfg.data;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_i     <= '0;
            r_s     <= '0;
            r_lvl   <= '0;
            r_len   <= '0;
        end else begin
            if (o_out.ready) r_ov <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_out_kind <= i_in.kind;
                        r_out_re   <= '0;
                        r_out_im   <= '0;
                        unique case (r2fft_pkg::t_kind'(i_in.kind))
                            r2fft_pkg::KIND_READ: r_state <= ST_RDW;
                            r2fft_pkg::KIND_RUN: begin
                                r_len   <= len_eff;
                                r_i     <= '0;
                                r_state <= ST_SWC;
                            end
                            default: r_ov <= 1'b1;
                        endcase
                    end
                end
                ST_RDW: begin
                    r_out_re <= r_rd[DW-1:0];
                    r_out_im <= r_rd[2*DW-1:DW];
                    r_ov     <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                ST_SWC, ST_SW3: begin
                    if (r_state == ST_SWC && r_i < rev) begin
                        r_state <= ST_SW1;
                    end else if (r_i == n_mask) begin
                        r_i     <= '0;
                        r_lvl   <= LW'(1);
                        r_state <= ST_BF0;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= ST_SWC;
                    end
                end
                ST_SW1: r_state <= ST_SW2;
                ST_SW2: r_state <= ST_SW3;
                ST_BF0: r_state <= ST_BF1;
                ST_BF1: r_state <= ST_BF2;
                ST_BF2: begin
                    r_s     <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    if (r_s == 3'd4) r_state <= ST_WRP;
                    else r_s <= r_s + 3'd1;
                end
                ST_WRP: r_state <= ST_WRQ;
                ST_WRQ: begin
                    r_s <= '0;
                    if (r_i != (n_mask >> 1)) begin
                        r_i     <= r_i + AW'(1);
                        r_state <= ST_BF0;
                    end else if (r_lvl != r_len) begin
                        r_i     <= '0;
                        r_lvl   <= r_lvl + LW'(1);
                        r_state <= ST_BF0;
                    end else if (r_inverse) begin
                        r_i     <= '0;
                        r_state <= ST_SC0;
                    end else begin
                        r_ov    <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                ST_SC0: r_state <= ST_SC1;
                ST_SC1: begin
                    if (r_i == n_mask) begin
                        r_ov    <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= ST_SC0;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
